### hw/rtl/tcp_capstart_window_update_top_macros.svh
// Assertion helpers for the window update block
`ifndef TCP_CAPSTART_WINDOW_UPDATE_TOP_MACROS_SVH
`define TCP_CAPSTART_WINDOW_UPDATE_TOP_MACROS_SVH

// check a property on every clock edge outside reset
`define TCW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every clock edge, reset included
`define TCW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the capacity-probe window update block.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int WINDOW_BITS_DEF = 32;
    localparam int RTT_BITS_DEF    = 32;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_SEGMENT_SIZE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SSTHRESH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SENDER_RATE   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PROBE_WINDOW  = 2'd3;

    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_SLOW    = 2'd1;
    localparam logic [1:0] MODE_LIMITED = 2'd2;

    typedef struct packed {
        logic [15:0] segments_acked;
        logic [31:0] rtt_us;
        logic [31:0] cwnd_bytes;
        logic [31:0] ssthresh_bytes;
        logic [31:0] high_tx_mark;
        logic [31:0] last_acked_seq;
    } t_ack_req;

    typedef struct packed {
        logic [31:0] new_cwnd_bytes;
        logic [1:0]  start_mode;
        logic        avoidance_applied;
        logic        expansion_flag;
    } t_win_rsp;

endpackage

### hw/rtl/tcp_capstart_window_update_top.sv
// ----------------------------------------------------------------------------
// tcp_capstart_window_update_top
// Packet-pair capacity probe and congestion window growth, one ACK at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_req_valid/o_req_ready carries one ACK request; output
//   channel o_rsp_valid/i_rsp_ready returns one window result per request.
//   Configuration is to be written through i_cfg_we/i_cfg_idx/i_cfg_data
//   by the user only while idle; the block does not enforce this. All
//   divisions run on one shared restoring divider, one quotient bit per
//   cycle over 64 bits. A request runs one division for the window in
//   segments, one for the capacity test when the probe window is reached
//   and the second best sample exceeds the first, two for limited slow
//   start and one for avoidance. Products (segment size times 80000 or
//   times itself) go through one 32x32 multiplier, registered.
//   One request is in flight; o_req_ready is low from acceptance until the
//   result is taken, and a new request can be taken the cycle after that.
//   The result register holds while i_rsp_ready is low.
//   Synchronous active-low reset restores the estimator state and the
//   register defaults (segment 536, limit 100, rate 5000, probe 90).
// ----------------------------------------------------------------------------
module tcp_capstart_window_update_top #(
    parameter int WINDOW_BITS = tcw_pkg::WINDOW_BITS_DEF,
    parameter int RTT_BITS    = tcw_pkg::RTT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_req_valid,
    output logic                               o_req_ready,
    input  tcw_pkg::t_ack_req                  i_req,
    output logic                               o_rsp_valid,
    input  logic                               i_rsp_ready,
    output tcw_pkg::t_win_rsp                  o_rsp,
    input  logic                               i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [tcw_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    localparam int WB = (WINDOW_BITS < 32) ? WINDOW_BITS : 32;
    localparam int RB = (RTT_BITS < 32) ? RTT_BITS : 32;
    localparam logic [31:0] WMASK = 32'((64'd1 << WB) - 64'd1);
    localparam logic [31:0] RMASK = 32'((64'd1 << RB) - 64'd1);

    typedef enum logic [3:0] {
        S_IDLE, S_WDIV, S_EST, S_DMUL1, S_DMUL2, S_DDIV, S_DEC,
        S_GROW, S_LDIV1, S_LDIV2, S_LEND, S_CA, S_CMUL, S_CDIV, S_OUT
    } t_state;

    t_state r_state;
    logic [15:0] r_seg;
    logic [9:0]  r_maxss, r_probe;
    logic [31:0] r_rate;
    logic r_await, r_first, r_nosample, r_exp;
    logic [31:0] r_bound, r_fs, r_bf, r_bs, r_mf, r_ms;
    tcw_pkg::t_ack_req r_req;
    logic [31:0] r_cwnd;
    logic [16:0] r_acked;
    logic [1:0]  r_mode;
    logic        r_ca;
    logic [63:0] r_prod;
    logic [63:0] r_quot, r_rem, r_dvsr;
    logic [6:0]  r_cnt;
    logic        r_rsp_valid;
    tcw_pkg::t_win_rsp r_rsp;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // divider step
    logic [64:0] div_sh;
    logic [64:0] div_tr;
    assign div_sh = {r_rem, r_quot[63]};
    assign div_tr = div_sh - {1'b0, r_dvsr};

    logic [31:0] lim;
    assign lim = 32'({16'd0, r_seg} * {22'd0, r_maxss});

    logic [31:0] sdiff;
    assign sdiff = r_req.last_acked_seq - r_bound;

    logic [32:0] sum;
    logic [31:0] add_v;
    logic [31:0] sat;
    assign sum = {1'b0, r_cwnd} + {1'b0, add_v};
    assign sat = (sum > {1'b0, WMASK}) ? WMASK : sum[31:0];

    always_comb begin
        mul_a = 32'(r_seg);
        mul_b = 32'd80000;
        add_v = 32'(r_seg);
        unique case (r_state)
            S_CMUL:  begin mul_a = 32'(r_seg); mul_b = 32'(r_seg); end
            S_LEND:  add_v = (r_dvsr == 64'd0) ? 32'hFFFF_FFFF : r_quot[31:0];
            S_CDIV:  add_v = (r_dvsr == 64'd0) ? 32'hFFFF_FFFF :
                             ((r_quot == 64'd0) ? 32'd1 :
                              ((|r_quot[63:32]) ? 32'hFFFF_FFFF : r_quot[31:0]));
            default: ;
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE) && !r_rsp_valid;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seg <= 16'd536; r_maxss <= 10'd100; r_rate <= 32'd5000; r_probe <= 10'd90;
            r_await <= 1'b1; r_first <= 1'b1; r_nosample <= 1'b1; r_exp <= 1'b0;
            r_bound <= '0; r_fs <= '0; r_bf <= '0; r_bs <= '0; r_mf <= '0; r_ms <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tcw_pkg::REG_SEGMENT_SIZE: r_seg   <= i_cfg_data[15:0];
                    tcw_pkg::REG_MAX_SSTHRESH: r_maxss <= i_cfg_data[9:0];
                    tcw_pkg::REG_SENDER_RATE:  r_rate  <= i_cfg_data;
                    tcw_pkg::REG_PROBE_WINDOW: r_probe <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (r_rsp_valid && i_rsp_ready) r_rsp_valid <= 1'b0;
            // divider iteration shared by all division states
            if (r_state == S_WDIV || r_state == S_DDIV || r_state == S_LDIV1 ||
                r_state == S_LDIV2 || r_state == S_CDIV) begin
                if (r_cnt != 7'd0) begin
                    r_cnt <= r_cnt - 7'd1;
                    if (!div_tr[64]) begin
                        r_rem  <= div_tr[63:0];
                        r_quot <= {r_quot[62:0], 1'b1};
                    end else begin
                        r_rem  <= div_sh[63:0];
                        r_quot <= {r_quot[62:0], 1'b0};
                    end
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    tcw_pkg::t_ack_req req_m;
                    if (i_req_valid && o_req_ready) begin
                        req_m = i_req;
                        req_m.rtt_us = i_req.rtt_us & RMASK;
                        req_m.cwnd_bytes = i_req.cwnd_bytes & WMASK;
                        req_m.ssthresh_bytes = i_req.ssthresh_bytes & WMASK;
                        r_req <= req_m;
                        r_cwnd <= i_req.cwnd_bytes & WMASK;
                        r_acked <= {1'b0, i_req.segments_acked};
                        r_quot <= {32'd0, i_req.cwnd_bytes & WMASK};
                        r_rem <= '0; r_dvsr <= 64'(r_seg); r_cnt <= 7'd64;
                        r_mode <= tcw_pkg::MODE_NONE; r_ca <= 1'b0;
                        r_state <= S_WDIV;
                    end
                end
                S_WDIV: if (r_cnt == 7'd0) r_state <= S_EST;
                S_EST: begin
                    // zero segment size: window in segments reads all ones
                    if (r_dvsr != 64'd0 && r_quot == 64'(r_probe) && r_bs > r_bf)
                        r_state <= S_DMUL1;
                    else
                        r_state <= S_GROW;
                    if (r_dvsr != 64'd0 && r_quot < 64'(r_probe)) begin
                        if (r_await) begin
                            r_bound <= r_req.high_tx_mark; r_await <= 1'b0;
                        end else if (r_first) begin
                            if (sdiff != 32'd0 && !sdiff[31]) begin
                                if (r_nosample) begin
                                    r_bf <= r_req.rtt_us; r_mf <= r_req.rtt_us;
                                end
                                r_fs <= r_req.rtt_us; r_first <= 1'b0;
                                r_bound <= r_req.high_tx_mark;
                            end
                        end else begin
                            logic [31:0] mf, ms, bs, s1, s2;
                            mf = r_mf;
                            ms = r_nosample ? r_req.rtt_us : r_ms;
                            bs = r_nosample ? r_req.rtt_us : r_bs;
                            s1 = r_fs; s2 = r_req.rtt_us;
                            r_nosample <= 1'b0; r_first <= 1'b1;
                            if (s1 == mf) begin
                                if (s2 < ms) begin bs = s2; ms = s2; end
                            end else if (s1 < mf) begin
                                r_bf <= s1; r_mf <= s1; bs = s2;
                                if (s2 < ms) ms = s2;
                            end else if (s2 < ms) begin
                                ms = s2;
                            end
                            r_bs <= bs;
                            r_ms <= ms;
                        end
                    end else if (r_dvsr != 64'd0 && r_quot == 64'(r_probe)) begin
                        if (r_bs < r_bf) r_exp <= 1'b0;
                        else if (r_bs == r_bf) r_exp <= 1'b1;
                    end
                end
                S_DMUL1: begin r_prod <= mul_p; r_state <= S_DMUL2; end
                S_DMUL2: begin
                    r_quot <= r_prod; r_rem <= '0; r_dvsr <= 64'(r_bs - r_bf);
                    r_cnt <= 7'd64; r_state <= S_DDIV;
                end
                S_DDIV: if (r_cnt == 7'd0) r_state <= S_DEC;
                S_DEC: begin
                    r_exp <= (r_quot > 64'(r_rate)) ||
                             (r_quot == 64'(r_rate) && r_rem != 64'd0);
                    r_state <= S_GROW;
                end
                S_GROW: begin
                    if (r_cwnd < r_req.ssthresh_bytes && r_acked != 17'd0) begin
                        r_acked <= r_acked - 17'd1;
                        if (r_cwnd <= lim || r_exp) begin
                            r_cwnd <= sat; r_mode <= tcw_pkg::MODE_SLOW;
                            r_state <= S_CA;
                        end else begin
                            r_mode <= tcw_pkg::MODE_LIMITED;
                            if (lim != 32'd0) begin
                                r_quot <= 64'(r_cwnd); r_rem <= '0;
                                r_dvsr <= 64'(lim); r_cnt <= 7'd64;
                                r_state <= S_LDIV1;
                            end else begin
                                r_state <= S_CA;
                            end
                        end
                    end else begin
                        r_state <= S_CA;
                    end
                end
                S_LDIV1: if (r_cnt == 7'd0) begin
                    // k = 2q + round bit, then seg / k
                    logic [32:0] k;
                    k = {r_quot[31:0], 1'b0} +
                        33'(({r_rem[62:0], 1'b0} >= r_dvsr) ? 1 : 0);
                    r_quot <= 64'(r_seg); r_rem <= '0; r_dvsr <= 64'(k);
                    r_cnt <= 7'd64; r_state <= S_LDIV2;
                end
                S_LDIV2: if (r_cnt == 7'd0) r_state <= S_LEND;
                S_LEND: begin
                    r_cwnd <= (r_dvsr == 64'd0) ? r_cwnd : sat;
                    r_state <= S_CA;
                end
                S_CA: begin
                    if (r_cwnd >= r_req.ssthresh_bytes && r_acked != 17'd0)
                        r_state <= S_CMUL;
                    else r_state <= S_OUT;
                end
                S_CMUL: begin
                    r_quot <= mul_p; r_rem <= '0; r_dvsr <= 64'(r_cwnd);
                    r_cnt <= 7'd64; r_state <= S_CDIV;
                end
                S_CDIV: if (r_cnt == 7'd0) begin
                    r_cwnd <= sat; r_ca <= 1'b1; r_state <= S_OUT;
                end
                S_OUT: begin
                    r_rsp.new_cwnd_bytes <= r_cwnd;
                    r_rsp.start_mode <= r_mode;
                    r_rsp.avoidance_applied <= r_ca;
                    r_rsp.expansion_flag <= r_exp;
                    r_rsp_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### hw/rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the window update block.
// ----------------------------------------------------------------------------
`include "tcp_capstart_window_update_top_macros.svh"

module tcw_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              o_req_ready,
    input logic              o_rsp_valid,
    input logic              i_rsp_ready,
    input tcw_pkg::t_win_rsp o_rsp
);
    `TCW_ASSERT(a_one_in_flight, i_clk, i_rst_n, o_rsp_valid |-> !o_req_ready, "ready while result pending")
    `TCW_ASSERT(a_busy_after_req, i_clk, i_rst_n, (i_req_valid && o_req_ready) |=> !o_req_ready && !o_rsp_valid, "no busy period after request")
    `TCW_ASSERT(a_rsp_hold, i_clk, i_rst_n, (o_rsp_valid && !i_rsp_ready) |=> o_rsp_valid && $stable(o_rsp), "result changed under stall")
    `TCW_ASSERT(a_mode_range, i_clk, i_rst_n, o_rsp_valid |-> o_rsp.start_mode != 2'd3, "bad start mode")
    `TCW_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_rsp_valid, "result after reset")
endmodule

bind tcp_capstart_window_update_top tcw_checker u_tcw_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_valid(i_req_valid),
    .o_req_ready(o_req_ready), .o_rsp_valid(o_rsp_valid),
    .i_rsp_ready(i_rsp_ready), .o_rsp(o_rsp)
);

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packet-pair capacity probe window update block.
// Requests are driven over a valid/ready channel, and an in-bench predictor
// computes the expected window result for each accepted request. A scoreboard
// compares every returned result, field by field, against the oldest
// expectation.
// ----------------------------------------------------------------------------
module tb_top;

    localparam bit [63:0] WIN_MAX = 64'hFFFF_FFFF;
    localparam int WDOG_LIMIT     = 20000;
    localparam int NUM_RANDOM     = 1230;

    class window_scoreboard;
        bit [63:0] seg, lim_segs, rate, probe;
        bit        wait_start, want_first, no_sample, expands;
        bit [31:0] boundary;
        bit [63:0] first_rtt, best_first, best_second, min_first, min_second;
        tcw_pkg::t_win_rsp exp_q[$];
        int        errors;

        function new();
            seg = 536; lim_segs = 100; rate = 5000; probe = 90;
            wait_start = 1; want_first = 1; no_sample = 1; expands = 0;
            boundary = 0; first_rtt = 0; best_first = 0; best_second = 0;
            min_first = 0; min_second = 0; errors = 0;
        endfunction

        function void set_reg(logic [tcw_pkg::CFG_IDX_BITS-1:0] idx, bit [31:0] val);
            case (idx)
                tcw_pkg::REG_SEGMENT_SIZE: seg      = 64'(val[15:0]);
                tcw_pkg::REG_MAX_SSTHRESH: lim_segs = 64'(val[9:0]);
                tcw_pkg::REG_SENDER_RATE:  rate     = 64'(val);
                tcw_pkg::REG_PROBE_WINDOW: probe    = 64'(val[9:0]);
            endcase
        endfunction

        function bit [63:0] div_ones(bit [63:0] a, bit [63:0] b);
            return (b == 0) ? '1 : a / b;
        endfunction

        function bit [63:0] add_sat(bit [63:0] a, bit [63:0] b);
            return (b > WIN_MAX - a) ? WIN_MAX : a + b;
        endfunction

        function void close_pair(bit [63:0] s2);
            if (first_rtt == min_first) begin
                if (s2 < min_second) begin
                    best_second = s2; min_second = s2;
                end
            end else if (first_rtt < min_first) begin
                best_first = first_rtt; best_second = s2; min_first = first_rtt;
                if (s2 < min_second) min_second = s2;
            end else if (s2 < min_second) begin
                min_second = s2;
            end
        endfunction

        function void decide_capacity();
            bit [63:0] disp, num, q, r;
            if (best_second < best_first) begin
                expands = 0;
            end else begin
                disp = best_second - best_first;
                if (disp == 0) begin
                    expands = 1;
                end else begin
                    num = seg * 64'd80000;
                    q = num / disp;
                    r = num % disp;
                    expands = (q > rate) || (q == rate && r != 0);
                end
            end
        endfunction

        function void update_probe(bit [63:0] cw, bit [63:0] rtt, bit [31:0] hi,
                                   bit [31:0] ackseq);
            bit [63:0] w;
            bit [31:0] d;
            w = div_ones(cw, seg);
            d = ackseq - boundary;
            if (w < probe) begin
                if (wait_start) begin
                    boundary = hi; wait_start = 0;
                end else if (want_first) begin
                    if (d != 0 && d < 32'h8000_0000) begin
                        if (no_sample) begin
                            best_first = rtt; min_first = rtt;
                        end
                        first_rtt = rtt; want_first = 0; boundary = hi;
                    end
                end else begin
                    if (no_sample) begin
                        best_second = rtt; min_second = rtt; no_sample = 0;
                    end
                    want_first = 1;
                    close_pair(rtt);
                end
            end else if (w == probe) begin
                decide_capacity();
            end
        endfunction

        function void note_request(tcw_pkg::t_ack_req r);
            bit [63:0] cw, ss, lim, q, rm, k, inc, add;
            int unsigned acked;
            tcw_pkg::t_win_rsp e;
            cw = 64'(r.cwnd_bytes);
            ss = 64'(r.ssthresh_bytes);
            acked = 32'(r.segments_acked);
            update_probe(cw, 64'(r.rtt_us), r.high_tx_mark, r.last_acked_seq);
            lim = lim_segs * seg;
            e.start_mode = tcw_pkg::MODE_NONE;
            e.avoidance_applied = 0;
            if (cw < ss && acked >= 1) begin
                if (cw <= lim || expands) begin
                    cw = add_sat(cw, seg);
                    e.start_mode = tcw_pkg::MODE_SLOW;
                end else begin
                    inc = 0;
                    if (lim != 0) begin
                        q = cw / lim;
                        rm = cw % lim;
                        k = 2 * q + ((2 * rm >= lim) ? 1 : 0);
                        inc = div_ones(seg, k);
                    end
                    cw = add_sat(cw, inc);
                    e.start_mode = tcw_pkg::MODE_LIMITED;
                end
                acked--;
            end
            if (cw >= ss && acked > 0) begin
                add = div_ones(seg * seg, cw);
                if (add < 1) add = 1;
                cw = add_sat(cw, add);
                e.avoidance_applied = 1;
            end
            e.new_cwnd_bytes = cw[31:0];
            e.expansion_flag = expands;
            exp_q.push_back(e);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(tcw_pkg::t_win_rsp got);
            tcw_pkg::t_win_rsp e;
            if (exp_q.size() == 0) begin
                report("unexpected result", got.new_cwnd_bytes, 32'd0);
            end else begin
                e = exp_q.pop_front();
                if (got.new_cwnd_bytes !== e.new_cwnd_bytes)
                    report("new_cwnd_bytes", got.new_cwnd_bytes, e.new_cwnd_bytes);
                if (got.start_mode !== e.start_mode)
                    report("start_mode", 32'(got.start_mode), 32'(e.start_mode));
                if (got.avoidance_applied !== e.avoidance_applied)
                    report("avoidance_applied", 32'(got.avoidance_applied),
                           32'(e.avoidance_applied));
                if (got.expansion_flag !== e.expansion_flag)
                    report("expansion_flag", 32'(got.expansion_flag),
                           32'(e.expansion_flag));
            end
        endtask
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_req_valid;
    logic                               o_req_ready;
    tcw_pkg::t_ack_req                  i_req;
    logic                               o_rsp_valid;
    logic                               i_rsp_ready;
    tcw_pkg::t_win_rsp                  o_rsp;
    logic                               i_cfg_we;
    logic [tcw_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx;
    logic [tcw_pkg::CFG_DATA_BITS-1:0]  i_cfg_data;

    window_scoreboard sb = new();
    int        snd_idle = 0;
    int        rcv_idle = 0;
    int        stall_cnt = 0;
    bit [31:0] seq_ack = 32'hFFFF_F000;
    bit [31:0] seq_hi  = 32'hFFFF_F800;

    tcp_capstart_window_update_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        i_rsp_ready <= ($urandom_range(99) >= rcv_idle);
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req_valid && o_req_ready) sb.note_request(i_req);
            if (o_rsp_valid && i_rsp_ready) sb.check_result(o_rsp);
            if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
                stall_cnt <= 0;
            end else if (stall_cnt >= WDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                stall_cnt <= stall_cnt + 1;
            end
        end
    end

    task send_request(tcw_pkg::t_ack_req r);
        if ($urandom_range(99) < snd_idle) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (!o_req_ready);
    endtask

    task drain();
        i_req_valid <= 1'b0;
        // let the monitor put the last accepted request on the scoreboard queue
        @(posedge i_clk);
        while (sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task write_regs(bit [31:0] seg, bit [31:0] lim, bit [31:0] rate, bit [31:0] probe);
        bit [31:0] vals[4];
        vals = '{seg, lim, rate, probe};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= tcw_pkg::CFG_IDX_BITS'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            sb.set_reg(tcw_pkg::CFG_IDX_BITS'(i), vals[i]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function tcw_pkg::t_ack_req mk(bit [15:0] acked, bit [31:0] rtt, bit [31:0] cw,
                                   bit [31:0] ss, bit [31:0] hi, bit [31:0] ackseq);
        tcw_pkg::t_ack_req r;
        r.segments_acked = acked;
        r.rtt_us = rtt;
        r.cwnd_bytes = cw;
        r.ssthresh_bytes = ss;
        r.high_tx_mark = hi;
        r.last_acked_seq = ackseq;
        return r;
    endfunction

    function tcw_pkg::t_ack_req random_ack();
        bit [63:0] seg, probe, cw;
        bit [15:0] acked;
        bit [31:0] ss;
        int unsigned pick;
        seg = (sb.seg == 0) ? 64'd536 : sb.seg;
        probe = sb.probe;
        pick = $urandom_range(99);
        acked = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        if (pick < 10)
            return mk(16'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
        if (pick < 60) begin
            // flight below the probe size: advance the ack stream and the send mark
            cw = seg * $urandom_range(0, 32'(probe - 1)) +
                 $urandom_range(0, 32'(seg - 1));
            if ($urandom_range(9) == 0) seq_ack -= $urandom_range(1, 5000);
            else seq_ack += $urandom_range(0, 4000);
            seq_hi = seq_ack + $urandom_range(0, 30000);
        end else if (pick < 75) begin
            cw = seg * probe + $urandom_range(0, 32'(seg - 1));
        end else begin
            cw = $urandom_range(0, 3) == 0 ? 64'($urandom) : seg * $urandom_range(0, 2048);
        end
        case ($urandom_range(3))
            0: ss = cw[31:0] + $urandom_range(1, 100000);
            1: ss = cw[31:0] - $urandom_range(0, 2000);
            2: ss = cw[31:0];
            default: ss = $urandom;
        endcase
        return mk(acked, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1000, 20000),
                  cw[31:0], ss, seq_hi, seq_ack);
    endfunction

    task run_directed();
        send_request(mk(16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        send_request(mk(16'd2, 32'hFFFF_FFFF, 32'd5360, 32'd100000, 32'd1000, 32'd0));
        // equal pair: zero dispersion, then probe
        send_request(mk(16'd1, 32'd5000, 32'd5360, 32'd100000, 32'd2000, 32'd1001));
        send_request(mk(16'd1, 32'd5000, 32'd5360, 32'd100000, 32'd2000, 32'd1002));
        send_request(mk(16'd1, 32'd1, 32'd48240, 32'd900000, 32'd2000, 32'd1500));
        send_request(mk(16'd3, 32'd1, 32'd60000, 32'd900000, 32'd2000, 32'd1500));
        // second sample below the first: negative dispersion
        send_request(mk(16'd1, 32'd3000, 32'd5360, 32'd100000, 32'd3000, 32'd2001));
        send_request(mk(16'd1, 32'd2000, 32'd5360, 32'd100000, 32'd3000, 32'd2002));
        send_request(mk(16'd1, 32'd7, 32'd48500, 32'd900000, 32'd3000, 32'd2002));
        // limited slow start, window above the limit
        send_request(mk(16'd1, 32'd9, 32'd60000, 32'd900000, 32'd3000, 32'd2002));
        send_request(mk(16'd4, 32'd9, 32'd5000000, 32'hFFFF_FFFF, 32'd3000, 32'd2002));
        // avoidance: zero window, saturation, small quotient
        send_request(mk(16'd2, 32'd9, 32'd0, 32'd0, 32'd3000, 32'd2002));
        send_request(mk(16'hFFFF, 32'd9, 32'hFFFF_FFFF, 32'd0, 32'd3000, 32'd2002));
        send_request(mk(16'hFFFF, 32'd9, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0, 32'd0));
        send_request(mk(16'd5, 32'd9, 32'h1000_0000, 32'd5, 32'd0, 32'd0));
        // sequence wrap: send mark near the top, ack just past zero
        send_request(mk(16'd1, 32'd100, 32'd536, 32'd600, 32'hFFFF_FFF0, 32'd0));
        send_request(mk(16'd1, 32'd100, 32'd536, 32'd600, 32'd10, 32'd5));
        send_request(mk(16'd1, 32'd200, 32'd536, 32'd600, 32'd10, 32'd6));
    endtask

    task run_random(int n);
        for (int i = 0; i < n; i++) begin
            if (stall_cnt == 0 && i % 97 == 0) begin
                // empty branch: the idling schedule is set in run_phase
            end
            send_request(random_ack());
        end
    endtask

    int done_cnt;

    task run_phase(int n);
        for (int i = 0; i < n; i++) begin
            if (done_cnt < NUM_RANDOM / 3) begin
                snd_idle = 22; rcv_idle = 72;
            end else if (done_cnt < 2 * NUM_RANDOM / 3) begin
                snd_idle = 72; rcv_idle = 22;
            end else begin
                snd_idle = 0; rcv_idle = 0;
            end
            send_request(random_ack());
            done_cnt++;
        end
        drain();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_data  <= '0;
        done_cnt = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain();
        run_phase(200);
        write_regs(32'd1460, 32'd20, 32'd100000, 32'd30);
        run_phase(200);
        write_regs(32'd65535, 32'd1023, 32'hFFFF_FFFF, 32'd1023);
        run_phase(150);
        write_regs(32'd1, 32'd1, 32'd1, 32'd1);
        run_phase(150);
        // zero segment size: neither estimator branch runs
        write_regs(32'd0, 32'd100, 32'd5000, 32'd90);
        run_phase(30);
        for (int p = 0; p < 5; p++) begin
            write_regs($urandom_range(64, 9000), $urandom_range(1, 1023),
                       $urandom_range(1, 200000), $urandom_range(1, 1023));
            run_phase(100);
        end

        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
